### sv/request_queue_insert_at_offset_assert.svh
// ----------------------------------------------------------------------------
// request queue assertion macros
// shared concurrent check wrappers, clocked on clk with async reset rst_n
// ----------------------------------------------------------------------------
`ifndef REQUEST_QUEUE_INSERT_AT_OFFSET_ASSERT_SVH
`define REQUEST_QUEUE_INSERT_AT_OFFSET_ASSERT_SVH

`ifndef SYNTH

// condition holds at every edge out of reset
`define RQIA_CHECK(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("rqi check failed");

// same-cycle implication
`define RQIA_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rqi implication failed");

// next-cycle implication
`define RQIA_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rqi next-cycle check failed");

`else

`define RQIA_CHECK(lbl, expr)
`define RQIA_IMPLY(lbl, ante, cons)
`define RQIA_NEXT(lbl, ante, cons)

`endif

`endif

### sv/rqi_pkg.sv
// ----------------------------------------------------------------------------
// rqi_pkg
// types and codes shared by the request queue modules
// ----------------------------------------------------------------------------
`default_nettype none

package rqi_pkg;

    localparam int ACTION_W    = 2;
    localparam int TAG_W       = 32;
    localparam int OFFSET_W    = 5;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;
    localparam int TDATA_W     = 136;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POP    = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OFFSET = 2'd3;

    // request tag sits in the low bits
    typedef struct packed {
        logic [TAG_W-1:0] power;
        logic [TAG_W-1:0] pipe_id;
        logic [TAG_W-1:0] tenant_tag;
        logic [TAG_W-1:0] request_tag;
    } entry_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        entry_t              entry;
        logic [ACTION_W-1:0] action;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] entry_count;
        entry_t                 entry;
        logic [STATUS_W-1:0]    status;
    } result_t;

    localparam int IN_W      = $bits(in_item_t);
    localparam int OUT_W     = $bits(result_t);
    localparam int OUT_PAD_W = TDATA_W - OUT_W;

endpackage

`default_nettype wire

### sv/request_queue_insert_at_offset.sv
// ----------------------------------------------------------------------------
// request_queue_insert_at_offset
// ordered request queue with append, insert at offset and pop head
// ----------------------------------------------------------------------------
//  channel   dir  carries
//  s_axis    in   one action: append, insert at offset or pop
//  m_axis    out  one result per action: status, popped entry, new count
//
//  append, insert at the tail, the unused action and every refused action go
//  from idle straight to the emit state, pop through the ram read state, and
//  insert ahead of the tail through shift, drain and place, since the single
//  ram write port moves one entry per cycle. one action is worked on at a
//  time; the next is taken in the cycle after the result enters the output
//  register, even while it waits there. a stalled output holds the sequencer.
//  reset empties the queue at once, with no sweep over the entry ram.
// ----------------------------------------------------------------------------
`default_nettype none

module request_queue_insert_at_offset #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // action[1:0], request_tag[33:2], tenant_tag[65:34], pipe_id[97:66],
    // power[129:98], offset[134:130], zero pad[135]
    input  wire logic [rqi_pkg::TDATA_W-1:0] s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // status[1:0], out_request_tag[33:2], out_tenant_tag[65:34],
    // out_pipe_id[97:66], out_power[129:98], entry_count[134:130], zero pad[135]
    output logic [rqi_pkg::TDATA_W-1:0]      m_axis_tdata
);

    rqi_pkg::in_item_t in_item;
    rqi_pkg::result_t  res;
    rqi_pkg::result_t  out_reg;
    logic              out_valid_reg;
    logic              res_valid;
    logic              res_take;

    assign in_item  = rqi_pkg::in_item_t'(s_axis_tdata[rqi_pkg::IN_W-1:0]);
    assign res_take = !out_valid_reg || m_axis_tready;

    rqi_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{rqi_pkg::OUT_PAD_W{1'b0}}, out_reg};

endmodule

`default_nettype wire

### sv/rqi_ram.sv
// ----------------------------------------------------------------------------
// rqi_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
`default_nettype none

module rqi_ram #(
    parameter  int WIDTH  = 128,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/rqi_seq.sv
// ----------------------------------------------------------------------------
// rqi_seq
// queue sequencer: circular entry ram, head/tail pointers and the shift
// sweep that opens a hole for a positional insert
// ----------------------------------------------------------------------------
`default_nettype none

`include "request_queue_insert_at_offset_assert.svh"

module rqi_seq #(
    parameter  int QUEUE_DEPTH = 16,
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH),
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1),
    localparam int CMP_W       = (CNT_W > rqi_pkg::OFFSET_W) ? CNT_W : rqi_pkg::OFFSET_W
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire rqi_pkg::in_item_t                 in_item,
    output logic                                   res_valid,
    input  wire logic                              res_take,
    output rqi_pkg::result_t                       res
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SHIFT = 6'b000010,
        S_DRAIN = 6'b000100,
        S_PLACE = 6'b001000,
        S_POPRD = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [ADDR_W-1:0]     head_reg, head_next;
    logic [ADDR_W-1:0]     tail_reg, tail_next;
    logic [ADDR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W-1:0]     pend_addr_reg, pend_addr_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic                  pend_reg, pend_next;
    rqi_pkg::entry_t       hold_reg, hold_next;
    rqi_pkg::result_t      res_reg, res_next;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    rqi_pkg::entry_t       ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    rqi_pkg::entry_t       ram_rdata;

    logic                  is_full;
    logic                  is_empty;
    logic                  offset_beyond;
    logic                  offset_at_tail;
    logic [CNT_W-1:0]      count_inc;
    logic [CNT_W-1:0]      count_dec;

    function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] r;
        begin
            if (p == ADDR_W'(QUEUE_DEPTH - 1))
            begin
                r = '0;
            end
            else
            begin
                r = p + 1'b1;
            end
            return r;
        end
    endfunction

    function automatic logic [ADDR_W-1:0] ptr_dec(input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] r;
        begin
            if (p == '0)
            begin
                r = ADDR_W'(QUEUE_DEPTH - 1);
            end
            else
            begin
                r = p - 1'b1;
            end
            return r;
        end
    endfunction

    rqi_ram #(
        .WIDTH ($bits(rqi_pkg::entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready       = (state_reg == S_IDLE);
    assign res_valid      = (state_reg == S_EMIT);
    assign res            = res_reg;

    assign is_full        = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_empty       = (count_reg == '0);
    assign offset_beyond  = (CMP_W'(in_item.offset) > CMP_W'(count_reg));
    assign offset_at_tail = (CMP_W'(in_item.offset) == CMP_W'(count_reg));
    assign count_inc      = count_reg + 1'b1;
    assign count_dec      = count_reg - 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        rd_ptr_next    = rd_ptr_reg;
        pend_addr_next = pend_addr_reg;
        rem_next       = rem_reg;
        pend_next      = 1'b0;
        hold_next      = hold_reg;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_waddr      = tail_reg;
        ram_wdata      = in_item.entry;
        ram_raddr      = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_next.status      = rqi_pkg::ST_OK;
                    res_next.entry       = '0;
                    res_next.entry_count = rqi_pkg::COUNT_OUT_W'(count_reg);
                    state_next           = S_EMIT;
                    case (in_item.action)
                        rqi_pkg::ACT_APPEND:
                        begin
                            if (is_full)
                            begin
                                res_next.status = rqi_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we               = 1'b1;
                                count_next           = count_inc;
                                tail_next            = ptr_inc(tail_reg);
                                res_next.entry_count = rqi_pkg::COUNT_OUT_W'(count_inc);
                            end
                        end
                        rqi_pkg::ACT_INSERT:
                        begin
                            if (is_full)
                            begin
                                res_next.status = rqi_pkg::ST_FULL;
                            end
                            else if (offset_beyond)
                            begin
                                res_next.status = rqi_pkg::ST_OFFSET;
                            end
                            else if (offset_at_tail)
                            begin
                                ram_we               = 1'b1;
                                count_next           = count_inc;
                                tail_next            = ptr_inc(tail_reg);
                                res_next.entry_count = rqi_pkg::COUNT_OUT_W'(count_inc);
                            end
                            else
                            begin
                                // move entries offset..count-1 up by one, last first
                                hold_next   = in_item.entry;
                                rd_ptr_next = ptr_dec(tail_reg);
                                rem_next    = count_reg - CNT_W'(in_item.offset);
                                state_next  = S_SHIFT;
                            end
                        end
                        rqi_pkg::ACT_POP:
                        begin
                            if (is_empty)
                            begin
                                res_next.status = rqi_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_POPRD;
                            end
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                // read one slot per cycle, write the previous read one slot up
                ram_raddr      = rd_ptr_reg;
                rd_ptr_next    = ptr_dec(rd_ptr_reg);
                pend_addr_next = rd_ptr_reg;
                rem_next       = rem_reg - 1'b1;
                pend_next      = 1'b1;
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ptr_inc(pend_addr_reg);
                    ram_wdata = ram_rdata;
                end
                if (rem_reg == CNT_W'(1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_inc(pend_addr_reg);
                ram_wdata = ram_rdata;
                state_next = S_PLACE;
            end
            S_PLACE:
            begin
                // the hole is now at the slot read last
                ram_we               = 1'b1;
                ram_waddr            = pend_addr_reg;
                ram_wdata            = hold_reg;
                count_next           = count_inc;
                tail_next            = ptr_inc(tail_reg);
                res_next.status      = rqi_pkg::ST_OK;
                res_next.entry       = '0;
                res_next.entry_count = rqi_pkg::COUNT_OUT_W'(count_inc);
                state_next           = S_EMIT;
            end
            S_POPRD:
            begin
                res_next.status      = rqi_pkg::ST_OK;
                res_next.entry       = ram_rdata;
                res_next.entry_count = rqi_pkg::COUNT_OUT_W'(count_dec);
                count_next           = count_dec;
                head_next            = ptr_inc(head_reg);
                state_next           = S_EMIT;
            end
            S_EMIT:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            pend_reg  <= 1'b0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            pend_reg  <= pend_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg    <= rd_ptr_next;
        pend_addr_reg <= pend_addr_next;
        hold_reg      <= hold_next;
        res_reg       <= res_next;
    end

    `RQIA_CHECK(a_count_in_range, count_reg <= CNT_W'(QUEUE_DEPTH))
    `RQIA_IMPLY(a_shift_has_work, state_reg == S_SHIFT, rem_reg != '0)
    `RQIA_IMPLY(a_write_only_when_busy, ram_we && state_reg == S_IDLE, in_valid && !is_full)
    `RQIA_NEXT(a_place_grows_count, state_reg == S_PLACE, count_reg == $past(count_reg) + 1'b1)
    `RQIA_NEXT(a_pop_reads_head,
               in_valid && in_ready && in_item.action == rqi_pkg::ACT_POP && !is_empty,
               state_reg == S_POPRD)

endmodule

`default_nettype wire
